### rtl/core/sgm_pkg.sv
`default_nettype none

package sgm_pkg;

  localparam int PIX_W          = 8;
  localparam int COL_W          = 10;
  localparam int ROW_W          = 12;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int GRAD_W         = 11;
  localparam int SQ_W           = 21;
  localparam int ROOT_W         = 8;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COLUMN_LIMIT   = 1024;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int MIN_DIM        = 3;

  localparam logic [FW_W-1:0]   FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0]   FH_RESET = FH_W'(480);
  localparam logic [PIX_W-1:0]  MAG_MAX  = PIX_W'(255);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sgm_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_EMIT   = 5'b10000
  } sgm_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic square;
    logic root_step;
    logic load_out;
    logic restart;
  } sgm_cmd_t;

  typedef struct packed {
    logic interior;
    logic root_last;
    logic out_free;
  } sgm_sts_t;

endpackage

`default_nettype wire

### rtl/core/sgm_stream_if.sv
`default_nettype none

interface sgm_pix_if;
  logic                     valid;
  logic                     ready;
  logic [sgm_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sgm_res_if;
  logic                     valid;
  logic                     ready;
  logic [sgm_pkg::PIX_W-1:0] magnitude;
  logic [sgm_pkg::COL_W-1:0] column;
  logic [sgm_pkg::ROW_W-1:0] row;
  logic                     last;

  modport source (output valid, output magnitude, output column, output row, output last,
                  input ready);
  modport sink   (input valid, input magnitude, input column, input row, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/sgm_ctrl.sv
`default_nettype none

module sgm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cfg_wr,
  input  wire sgm_pkg::sgm_sts_t sts,
  output sgm_pkg::sgm_cmd_t      cmd
);

  sgm_pkg::sgm_state_t state_r;
  sgm_pkg::sgm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.restart   = cfg_wr;
    in_ready      = 1'b0;
    case (state_r)
      sgm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sgm_pkg::ST_READ;
        end
      end
      sgm_pkg::ST_READ: begin
        cmd.update = 1'b1;
        state_nxt  = sts.interior ? sgm_pkg::ST_SQUARE : sgm_pkg::ST_IDLE;
      end
      sgm_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = sgm_pkg::ST_ROOT;
      end
      sgm_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = sgm_pkg::ST_EMIT;
        end
      end
      sgm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sgm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/sgm_datapath.sv
`default_nettype none

module sgm_datapath #(
  parameter int LINE_DEPTH = sgm_pkg::COLUMN_LIMIT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sgm_pkg::sgm_cmd_t             cmd,
  output sgm_pkg::sgm_sts_t                  sts,
  input  wire logic [sgm_pkg::FW_W-1:0]      frame_width,
  input  wire logic [sgm_pkg::FH_W-1:0]      frame_height,
  input  wire logic [sgm_pkg::PIX_W-1:0]     in_pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sgm_pkg::PIX_W-1:0]          out_magnitude,
  output logic [sgm_pkg::COL_W-1:0]          out_column,
  output logic [sgm_pkg::ROW_W-1:0]          out_row,
  output logic                               out_last
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = sgm_pkg::PIX_W;
  localparam int GW = sgm_pkg::GRAD_W;
  localparam int SW = sgm_pkg::SQ_W;
  localparam int RW = sgm_pkg::ROOT_W;

  logic [PW-1:0] above_mem [LINE_DEPTH];
  logic [PW-1:0] two_mem   [LINE_DEPTH];

  logic [PW-1:0]              pix_r;
  logic [PW-1:0]              above_rd_r;
  logic [PW-1:0]              two_rd_r;
  logic [PW-1:0]              win_r [6];
  logic [AW-1:0]              col_r;
  logic [sgm_pkg::ROW_W-1:0]  row_r;

  logic signed [GW-1:0]       gx_r;
  logic signed [GW-1:0]       gy_r;
  logic [SW-1:0]              sq_r;
  logic [RW-1:0]              root_r;
  logic [RW-1:0]              bit_r;
  logic [sgm_pkg::COL_W-1:0]  res_col_r;
  logic [sgm_pkg::ROW_W-1:0]  res_row_r;
  logic                       res_last_r;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [PW-1:0]              out_mag_r;
  logic [sgm_pkg::COL_W-1:0]  out_col_r;
  logic [sgm_pkg::ROW_W-1:0]  out_row_r;
  logic                       out_last_r;

  logic [sgm_pkg::FW_W-1:0]   eff_w;
  logic [sgm_pkg::FH_W-1:0]   eff_h;
  logic                       col_end;
  logic                       row_end;
  logic                       interior;

  logic signed [GW-1:0]       t_s, m_s, b_s, l0_s, l1_s, l2_s, c0_s, c2_s;
  logic signed [GW-1:0]       gx_c;
  logic signed [GW-1:0]       gy_c;
  logic signed [2*GW-1:0]     gx2;
  logic signed [2*GW-1:0]     gy2;
  logic [SW-1:0]              sq_nxt;
  logic [RW-1:0]              trial;
  logic [2*RW-1:0]            trial_sq;

  always_comb begin
    if (frame_width < sgm_pkg::FW_W'(sgm_pkg::MIN_DIM)) begin
      eff_w = sgm_pkg::FW_W'(sgm_pkg::MIN_DIM);
    end else if (frame_width > sgm_pkg::FW_W'(LINE_DEPTH)) begin
      eff_w = sgm_pkg::FW_W'(LINE_DEPTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height < sgm_pkg::FH_W'(sgm_pkg::MIN_DIM)) begin
      eff_h = sgm_pkg::FH_W'(sgm_pkg::MIN_DIM);
    end else if (frame_height > sgm_pkg::FH_W'(sgm_pkg::HEIGHT_LIMIT)) begin
      eff_h = sgm_pkg::FH_W'(sgm_pkg::HEIGHT_LIMIT);
    end else begin
      eff_h = frame_height;
    end
  end

  assign col_end  = (sgm_pkg::FW_W'(col_r) == eff_w - sgm_pkg::FW_W'(1));
  assign row_end  = (sgm_pkg::FH_W'(row_r) == eff_h - sgm_pkg::FH_W'(1));
  assign interior = (col_r >= AW'(2)) && (row_r >= sgm_pkg::ROW_W'(2));

  always_comb begin
    t_s  = $signed(GW'(two_rd_r));
    m_s  = $signed(GW'(above_rd_r));
    b_s  = $signed(GW'(pix_r));
    l0_s = $signed(GW'(win_r[0]));
    l1_s = $signed(GW'(win_r[1]));
    l2_s = $signed(GW'(win_r[2]));
    c0_s = $signed(GW'(win_r[3]));
    c2_s = $signed(GW'(win_r[5]));
    gx_c = (t_s - l0_s) + ((m_s - l1_s) <<< 1) + (b_s - l2_s);
    gy_c = (l2_s + (c2_s <<< 1) + b_s) - (l0_s + (c0_s <<< 1) + t_s);
  end

  assign gx2    = gx_r * gx_r;
  assign gy2    = gy_r * gy_r;
  assign sq_nxt = {1'b0, gx2[SW-2:0]} + {1'b0, gy2[SW-2:0]};

  assign trial    = root_r | bit_r;
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r      <= in_pixel;
      above_rd_r <= above_mem[col_r];
      two_rd_r   <= two_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      above_mem[col_r] <= pix_r;
      two_mem[col_r]   <= above_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.update) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= two_rd_r;
      win_r[4] <= above_rd_r;
      win_r[5] <= pix_r;
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + sgm_pkg::ROW_W'(1);
      end else begin
        col_r <= col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      gx_r       <= gx_c;
      gy_r       <= gy_c;
      res_col_r  <= sgm_pkg::COL_W'(col_r - AW'(1));
      res_row_r  <= row_r - sgm_pkg::ROW_W'(1);
      res_last_r <= col_end && row_end;
    end
    if (cmd.square) begin
      sq_r   <= sq_nxt;
      root_r <= '0;
      bit_r  <= {1'b1, {(RW-1){1'b0}}};
    end else if (cmd.root_step) begin
      if (trial_sq <= sq_r[2*RW-1:0]) begin
        root_r <= trial;
      end
      bit_r <= bit_r >> 1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mag_r  <= (sq_r[SW-1:2*RW] != '0) ? sgm_pkg::MAG_MAX : root_r;
      out_col_r  <= res_col_r;
      out_row_r  <= res_row_r;
      out_last_r <= res_last_r;
    end
  end

  assign sts.interior  = interior;
  assign sts.root_last = bit_r[0];
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

### rtl/core/sobel_gradient_magnitude.sv
// Sequence: a border pixel passes through the idle and read states only; an interior pixel then
// goes through the square state, the 8-step bit-serial square root (one 8x8 trial square per
// cycle) and the emit state, which registers its result. Only one pixel is in flight; the next
// is taken when the controller is back in idle, later while a result waits in the output register.
// Reset: synchronous, active low; clears counters, window and control, width 640, height 480.
// Line stores are not cleared; entries read before they are first written feed only border pixels.
`default_nettype none

module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sgm_pix_if.sink                             in_chan,
  sgm_res_if.source                           out_chan,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [sgm_pkg::PADDR_W-1:0]    cfg_paddr,
  input  wire logic [sgm_pkg::PDATA_W-1:0]    cfg_pwdata,
  output logic [sgm_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int LINE_DEPTH =
    (MAX_WIDTH < sgm_pkg::COLUMN_LIMIT) ? MAX_WIDTH : sgm_pkg::COLUMN_LIMIT;

  logic [sgm_pkg::FW_W-1:0] frame_width_r;
  logic [sgm_pkg::FH_W-1:0] frame_height_r;
  logic                     cfg_wr;
  sgm_pkg::sgm_reg_t        cfg_reg;
  sgm_pkg::sgm_cmd_t        cmd;
  sgm_pkg::sgm_sts_t        sts;
  logic                     in_ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_reg    = sgm_pkg::sgm_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sgm_pkg::FW_RESET;
      frame_height_r <= sgm_pkg::FH_RESET;
    end else if (cfg_wr) begin
      case (cfg_reg)
        sgm_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[sgm_pkg::FW_W-1:0];
        sgm_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[sgm_pkg::FH_W-1:0];
        default: begin
          frame_width_r <= frame_width_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      sgm_pkg::REG_FRAME_WIDTH:  cfg_prdata = sgm_pkg::PDATA_W'(frame_width_r);
      sgm_pkg::REG_FRAME_HEIGHT: cfg_prdata = sgm_pkg::PDATA_W'(frame_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  assign in_chan.ready = in_ready;

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgm_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .in_pixel      (in_chan.pixel),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_magnitude (out_chan.magnitude),
    .out_column    (out_chan.column),
    .out_row       (out_chan.row),
    .out_last      (out_chan.last)
  );

endmodule

`default_nettype wire

### rtl/core/sgm_checker.sv
`default_nettype none

module sgm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sgm_pkg::PIX_W-1:0]     out_magnitude,
  input wire logic [sgm_pkg::COL_W-1:0]     out_column,
  input wire logic [sgm_pkg::ROW_W-1:0]     out_row,
  input wire logic                          out_last
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude) && $stable(out_column)
      && $stable(out_row) && $stable(out_last))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("pixel taken while previous pixel in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_xfer))
    else $error("result appeared right after a pixel transfer");

  a_interior_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column != '0) && (out_row != '0))
    else $error("result on a border coordinate");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_magnitude (out_chan.magnitude),
  .out_column    (out_chan.column),
  .out_row       (out_chan.row),
  .out_last      (out_chan.last)
);

`default_nettype wire

### tb/sv/sgm_edge_checker.sv
`timescale 1ns / 100ps

module sgm_edge_checker
  import sgm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  sgm_pix_if                 pix_bus,
  sgm_res_if                 res_bus,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  input  logic [PDATA_W-1:0] cfg_prdata,
  input  logic               cfg_pready,
  output int                 mismatch_count,
  output int                 pending_results
);

  localparam int WIDTH_CAP = (MAX_WIDTH_DEF < COLUMN_LIMIT) ? MAX_WIDTH_DEF : COLUMN_LIMIT;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last;
  } edge_point_t;

  edge_point_t      gradient_queue[$];
  logic [PIX_W-1:0] line_prev [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH_DEF];
  int               taps [6];
  int               col_pos;
  int               row_pos;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  initial mismatch_count = 0;

  function automatic logic [PIX_W-1:0] root_floor_sat(int unsigned v);
    logic [PIX_W-1:0] r;
    int unsigned      trial;
    if (v >= 65536) return MAG_MAX;
    r = '0;
    for (int b = PIX_W - 1; b >= 0; b--) begin
      trial = r | (1 << b);
      if (trial * trial <= v) r = trial[PIX_W-1:0];
    end
    return r;
  endfunction

  task automatic report(string msg);
    $display("%0t ns: error: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic restart_frame();
    foreach (taps[i]) taps[i] = 0;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic predict_gradient(logic [PIX_W-1:0] px);
    int          w, h, c, r, top, mid, bot, gx, gy;
    edge_point_t pt;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    top = line_prev2[c];
    mid = line_prev[c];
    bot = px;
    if (c >= 2 && r >= 2) begin
      gx = (top - taps[0]) + 2 * (mid - taps[1]) + (bot - taps[2]);
      gy = (taps[2] + 2 * taps[5] + bot) - (taps[0] + 2 * taps[3] + top);
      pt.magnitude = root_floor_sat(gx * gx + gy * gy);
      pt.column    = COL_W'(c - 1);
      pt.row       = ROW_W'(r - 1);
      pt.last      = (c == w - 1) && (r == h - 1);
      gradient_queue.push_back(pt);
    end
    taps[0] = taps[3];
    taps[1] = taps[4];
    taps[2] = taps[5];
    taps[3] = top;
    taps[4] = mid;
    taps[5] = bot;
    line_prev2[c] = line_prev[c];
    line_prev[c]  = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic check_result();
    edge_point_t got, want;
    got = {res_bus.magnitude, res_bus.column, res_bus.row, res_bus.last};
    if (gradient_queue.size() == 0) begin
      report($sformatf("unexpected result for column %0d row %0d", got.column, got.row));
      return;
    end
    want = gradient_queue.pop_front();
    if (got.magnitude !== want.magnitude)
      report($sformatf("magnitude at (%0d,%0d) is %0d, expected %0d",
                       want.column, want.row, got.magnitude, want.magnitude));
    if (got.column !== want.column)
      report($sformatf("column is %0d, expected %0d", got.column, want.column));
    if (got.row !== want.row)
      report($sformatf("row is %0d, expected %0d", got.row, want.row));
    if (got.last !== want.last)
      report($sformatf("last at (%0d,%0d) is %0b, expected %0b",
                       want.column, want.row, got.last, want.last));
  endtask

  task automatic register_access();
    sgm_reg_t         sel;
    logic [PDATA_W-1:0] want;
    sel = sgm_reg_t'(cfg_paddr[2]);
    if (cfg_pwrite) begin
      case (sel)
        REG_FRAME_WIDTH:  width_reg  = cfg_pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: height_reg = cfg_pwdata[FH_W-1:0];
        default: ;
      endcase
      restart_frame();
    end else begin
      want = (sel == REG_FRAME_WIDTH) ? PDATA_W'(width_reg) : PDATA_W'(height_reg);
      if (cfg_prdata !== want)
        report($sformatf("register %s reads %0d, expected %0d", sel.name(), cfg_prdata, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      foreach (line_prev[i]) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      restart_frame();
      gradient_queue.delete();
    end else begin
      if (res_bus.valid && res_bus.ready) check_result();
      if (cfg_psel && cfg_penable && cfg_pready) register_access();
      if (pix_bus.valid && pix_bus.ready) predict_gradient(pix_bus.pixel);
    end
    pending_results = gradient_queue.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sgm_pkg::*;

  localparam int RANDOM_ITEMS = 1278;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;
  int                 mismatch_count;
  int                 pending_results;
  int                 idle_cycles = 0;
  int                 hold_left = 0;
  int                 random_sent;
  bit                 steady;
  bit                 paused_once;

  sgm_pix_if pix_if ();
  sgm_res_if res_if ();

  sobel_gradient_magnitude i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (pix_if),
    .out_chan    (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sgm_edge_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_bus         (pix_if),
    .res_bus         (res_if),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] prev);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1:       return prev + 8'($urandom_range(0, 6)) - 8'd3;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= pick_gap() - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_psel && cfg_penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("sobel_gradient_magnitude: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] px);
    int gap;
    gap = (!steady && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(logic write, sgm_reg_t sel, logic [PDATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= PADDR_W'(sel) << 2;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // upper data bits carry junk; only the register width is kept
  task automatic set_frame(int w, int h);
    wait_drained();
    cfg_access(1'b1, REG_FRAME_WIDTH, (PDATA_W'($urandom) << FW_W) | PDATA_W'(w));
    cfg_access(1'b1, REG_FRAME_HEIGHT, (PDATA_W'($urandom) << FH_W) | PDATA_W'(h));
    cfg_access(1'b0, REG_FRAME_WIDTH, '0);
    cfg_access(1'b0, REG_FRAME_HEIGHT, '0);
  endtask

  task automatic send_noise(int count);
    logic [PIX_W-1:0] px;
    px = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      px = pick_pixel(px);
      send_pixel(px);
    end
  endtask

  task automatic run_random_phase();
    int               w, h, we, he, pixels;
    logic [PIX_W-1:0] px;
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(0, 2);
      1, 2:    w = $urandom_range(13, 40);
      default: w = $urandom_range(3, 12);
    endcase
    h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    we = (w < MIN_DIM) ? MIN_DIM : w;
    he = (h < MIN_DIM) ? MIN_DIM : h;
    pixels = $urandom_range(1, 3) * we * he;
    if ($urandom_range(0, 1)) pixels += $urandom_range(0, we * he - 1);
    if (pixels > RANDOM_ITEMS - random_sent) pixels = RANDOM_ITEMS - random_sent;
    set_frame(w, h);
    steady = ($urandom_range(0, 3) == 0);
    px = 8'($urandom);
    for (int i = 0; i < pixels; i++) begin
      px = pick_pixel(px);
      send_pixel(px);
      random_sent++;
      // hold the stream until every pending result is out
      if (i == pixels / 2 && (!paused_once || $urandom_range(0, 4) == 0)) begin
        wait_drained();
        paused_once = 1'b1;
      end
    end
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    steady       = 1'b1;
    paused_once  = 1'b0;
    random_sent  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, REG_FRAME_WIDTH, '0);
    cfg_access(1'b0, REG_FRAME_HEIGHT, '0);

    // undersized frame clamps to 3x3; steep horizontal gradient saturates
    set_frame(0, 2);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd128 : 8'd255);
    // partial frame, then restart through a register write
    for (int i = 0; i < 4; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
    set_frame(1, 1);
    for (int i = 0; i < 9; i++) send_pixel((i < 6) ? 8'd0 : 8'd255);

    steady = 1'b0;
    // oversized height clamps; partial frame only
    set_frame(3, 8191);
    send_noise(3 * 50);

    while (random_sent < RANDOM_ITEMS) run_random_phase();

    steady = 1'b0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("sobel_gradient_magnitude: match");
    end else begin
      $display("sobel_gradient_magnitude: mismatch");
    end
    $finish;
  end

endmodule
